// ----- src/assert_macros.svh -----
// Assertion helpers used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk_, rst_n_, prop, msg) \
	lbl: assert property (@(posedge clk_) disable iff (!rst_n_) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk_, rst_n_, expr, msg) \
	lbl: assert property (@(posedge clk_) disable iff (!rst_n_) !(expr)) else $error(msg);

`endif

// ----- src/rfms_pkg.sv -----
`timescale 1ns / 1ps
package rfms_pkg;

	localparam int MAX_PARTICIPANTS_DEF = 64;

	localparam int HEIGHT_W  = 31;
	localparam int MASK_W    = 64;
	localparam int IDX_W     = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 136;

	localparam logic [CFG_IDX_W-1:0] REG_PARTICIPANT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_COUNT    = 1'd1;

	localparam logic [CFG_W-1:0] REQUIRED_COUNT_RST = 7'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic scan_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic scan_last;
	} sts_t;

endpackage

// ----- src/rotating_first_m_selector.sv -----
`timescale 1ns / 1ps
// channel  | dir | handshake        | payload
// s_axis   | in  | s_tvalid/tready  | s_tdata: height, ready_mask
// m_axis   | out | m_tvalid/tready  | m_tdata: selected_mask, last_index, found, received_mask
// cfg      | in  | cfg_we           | cfg_addr, cfg_wdata (no read-back)
//
// A request is loaded, then the remainder of height by participant_count is formed bit-serially,
// then s participants are scanned from it (s = 1..participant_count) before the final write-back.
// A finished result sits in the output register while the next request is accepted.
// Output stall holds only the final write-back; async reset clears config to its
// defaults, the received mask to zero and the output to empty.
module rotating_first_m_selector #(
	parameter int MAX_PARTICIPANTS = rfms_pkg::MAX_PARTICIPANTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rfms_pkg::S_TDATA_W-1:0]    s_tdata,  // height[30:0], ready_mask[94:31]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rfms_pkg::M_TDATA_W-1:0]    m_tdata,  // selected_mask[63:0], last_index[69:64],
	                                                    // found[70], received_mask[134:71]
	input  logic                              cfg_we,
	input  logic [rfms_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [rfms_pkg::CFG_W-1:0]        cfg_wdata
);

	`include "assert_macros.svh"

	rfms_pkg::cmd_t cmd;
	rfms_pkg::sts_t sts;

	logic [rfms_pkg::MASK_W-1:0] selected_mask;
	logic [rfms_pkg::IDX_W-1:0]  last_index;
	logic                        found;
	logic [rfms_pkg::MASK_W-1:0] received_mask;

	rfms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rfms_dp #(
		.MAX_PARTICIPANTS (MAX_PARTICIPANTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_height     (s_tdata[rfms_pkg::HEIGHT_W-1:0]),
		.in_ready_mask (s_tdata[rfms_pkg::HEIGHT_W +: rfms_pkg::MASK_W]),
		.cmd           (cmd),
		.sts           (sts),
		.selected_mask (selected_mask),
		.last_index    (last_index),
		.found         (found),
		.received_mask (received_mask)
	);

	assign m_tdata = {1'b0, received_mask, found, last_index, selected_mask};

	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && m_tvalid && !m_tready,
		"result overwritten while still pending")
	`ASSERT_NEVER(a_busy_not_ready, clk, arst_n,
		s_tready && (cmd.div_step || cmd.scan_step || cmd.out_load),
		"input ready while a request is in progress")
	`ASSERT_HOLDS(a_found_nonzero, clk, arst_n, m_tvalid && found |->
		selected_mask != '0 && (selected_mask & ~received_mask) == '0,
		"found result with empty or unrecorded selection")
	`ASSERT_HOLDS(a_miss_zero, clk, arst_n, m_tvalid && !found |->
		selected_mask == '0 && last_index == '0,
		"miss result carries nonzero selection")

endmodule

// ----- src/rfms_ctrl.sv -----
`timescale 1ns / 1ps
module rfms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  rfms_pkg::sts_t sts,
	output rfms_pkg::cmd_t cmd
);

	rfms_pkg::state_t state_q, state_nx;
	logic             out_vld_q;
	logic             out_free;

	assign out_free  = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rfms_pkg::ST_IDLE: begin
				if (in_valid)
					state_nx = rfms_pkg::ST_DIV;
			end
			rfms_pkg::ST_DIV: begin
				if (sts.div_last)
					state_nx = rfms_pkg::ST_SCAN;
			end
			rfms_pkg::ST_SCAN: begin
				if (sts.scan_last)
					state_nx = rfms_pkg::ST_FIN;
			end
			rfms_pkg::ST_FIN: begin
				if (out_free)
					state_nx = rfms_pkg::ST_IDLE;
			end
			default: state_nx = rfms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rfms_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rfms_pkg::ST_DIV:  cmd.div_step  = 1'b1;
			rfms_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			rfms_pkg::ST_FIN:  cmd.out_load  = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rfms_pkg::ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

endmodule

// ----- src/rfms_dp.sv -----
`timescale 1ns / 1ps
module rfms_dp #(
	parameter int MAX_PARTICIPANTS = rfms_pkg::MAX_PARTICIPANTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rfms_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [rfms_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [rfms_pkg::HEIGHT_W-1:0]   in_height,
	input  logic [rfms_pkg::MASK_W-1:0]     in_ready_mask,
	input  rfms_pkg::cmd_t                  cmd,
	output rfms_pkg::sts_t                  sts,
	output logic [rfms_pkg::MASK_W-1:0]     selected_mask,
	output logic [rfms_pkg::IDX_W-1:0]      last_index,
	output logic                            found,
	output logic [rfms_pkg::MASK_W-1:0]     received_mask
);

	localparam int PW  = MAX_PARTICIPANTS;
	localparam int CW  = $clog2(MAX_PARTICIPANTS + 1);
	localparam int RW  = $clog2(MAX_PARTICIPANTS);
	localparam int TW  = RW + 1;
	localparam int DCW = $clog2(rfms_pkg::HEIGHT_W);

	// config and sticky state
	logic [CW-1:0]              n_q;
	logic [rfms_pkg::CFG_W-1:0] need_q;
	logic [PW-1:0]              acc_q;

	// working registers
	logic [rfms_pkg::HEIGHT_W-1:0] hgt_q;
	logic [PW-1:0]                 ready_q;
	logic [RW-1:0]                 rem_q;
	logic [DCW-1:0]                dcnt_q;
	logic [CW-1:0]                 step_q;
	logic [rfms_pkg::CFG_W-1:0]    picks_q;
	logic [PW-1:0]                 mask_q;
	logic                          found_q;
	logic [RW-1:0]                 last_q;

	// output register
	logic [rfms_pkg::MASK_W-1:0] sel_out_q;
	logic [rfms_pkg::IDX_W-1:0]  last_out_q;
	logic                        found_out_q;
	logic [rfms_pkg::MASK_W-1:0] recv_out_q;

	logic [CW-1:0]              n_wr;
	logic [TW-1:0]              div_t;
	logic [TW-1:0]              n_ext;
	logic [TW-1:0]              rem_nx;
	logic                       hit;
	logic [rfms_pkg::CFG_W-1:0] picks_nx;
	logic                       reach;
	logic [CW-1:0]              k_inc;
	logic                       wrap;
	logic [PW-1:0]              bit_k;

	// participant count of zero acts as one, counts above the maximum saturate
	always_comb begin
		if (cfg_wdata == '0)
			n_wr = CW'(1);
		else if (cfg_wdata > rfms_pkg::CFG_W'(MAX_PARTICIPANTS))
			n_wr = CW'(MAX_PARTICIPANTS);
		else
			n_wr = CW'(cfg_wdata);
	end

	// restoring remainder, one height bit per step
	assign div_t  = {rem_q, hgt_q[rfms_pkg::HEIGHT_W-1]};
	assign n_ext  = TW'(n_q);
	assign rem_nx = (div_t >= n_ext) ? TW'(div_t - n_ext) : div_t;

	assign hit      = ready_q[rem_q];
	assign picks_nx = picks_q + 1'b1;
	assign reach    = hit && (picks_nx >= need_q);
	assign k_inc    = CW'(rem_q) + 1'b1;
	assign wrap     = (k_inc == n_q);
	assign bit_k    = PW'(1) << rem_q;

	assign sts.div_last  = (dcnt_q == '0);
	assign sts.scan_last = reach || (step_q == CW'(n_q - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= CW'(MAX_PARTICIPANTS);
			need_q <= rfms_pkg::REQUIRED_COUNT_RST;
			acc_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					rfms_pkg::REG_PARTICIPANT_COUNT: n_q    <= n_wr;
					rfms_pkg::REG_REQUIRED_COUNT:    need_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.scan_step && hit)
				acc_q <= acc_q | bit_k;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hgt_q   <= in_height;
			ready_q <= in_ready_mask[PW-1:0];
			rem_q   <= '0;
			dcnt_q  <= DCW'(rfms_pkg::HEIGHT_W - 1);
			step_q  <= '0;
			picks_q <= '0;
			mask_q  <= '0;
			found_q <= 1'b0;
			last_q  <= '0;
		end else if (cmd.div_step) begin
			hgt_q  <= hgt_q << 1;
			rem_q  <= rem_nx[RW-1:0];
			dcnt_q <= dcnt_q - 1'b1;
		end else if (cmd.scan_step) begin
			if (hit) begin
				mask_q  <= mask_q | bit_k;
				picks_q <= picks_nx;
			end
			if (reach) begin
				found_q <= 1'b1;
				last_q  <= rem_q;
			end
			rem_q  <= wrap ? '0 : k_inc[RW-1:0];
			step_q <= step_q + 1'b1;
		end
		if (cmd.out_load) begin
			sel_out_q   <= found_q ? rfms_pkg::MASK_W'(mask_q) : '0;
			last_out_q  <= found_q ? rfms_pkg::IDX_W'(last_q) : '0;
			found_out_q <= found_q;
			recv_out_q  <= rfms_pkg::MASK_W'(acc_q);
		end
	end

	assign selected_mask = sel_out_q;
	assign last_index    = last_out_q;
	assign found         = found_out_q;
	assign received_mask = recv_out_q;

endmodule

// ----- tb/rotating_first_m_selector_tb.sv -----
`timescale 1ns / 1ps
module rotating_first_m_selector_tb;
	import rfms_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int TAIL_CYCLES = 120;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic [MASK_W-1:0] selected;
		logic [IDX_W-1:0]  last_index;
		logic              found;
		logic [MASK_W-1:0] received;
	} selection_t;

	class selection_tracker;
		logic [CFG_W-1:0]  participant_reg;
		logic [CFG_W-1:0]  required_reg;
		logic [MASK_W-1:0] received_acc;
		selection_t        expected_q[$];
		int                mismatches;

		function new();
			participant_reg = 7'd64;
			required_reg    = REQUIRED_COUNT_RST;
			received_acc    = '0;
			mismatches      = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx == REG_PARTICIPANT_COUNT) begin
				participant_reg = value;
			end else begin
				required_reg = value;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// rotated scan from height mod n, stops at the required pick
		function void note_request(logic [HEIGHT_W-1:0] height, logic [MASK_W-1:0] ready);
			selection_t r;
			int n;
			int k;
			int picks;
			n = int'(participant_reg);
			if (n == 0) n = 1;
			if (n > MAX_PARTICIPANTS_DEF) n = MAX_PARTICIPANTS_DEF;
			k = int'(height) % n;
			r = '0;
			picks = 0;
			for (int j = 0; j < n; j++) begin
				if (ready[k]) begin
					received_acc[k] = 1'b1;
					r.selected[k] = 1'b1;
					picks++;
					if (picks >= int'(required_reg)) begin
						r.found = 1'b1;
						r.last_index = IDX_W'(k);
						break;
					end
				end
				k = (k + 1 == n) ? 0 : k + 1;
			end
			if (!r.found) begin
				r.selected = '0;
				r.last_index = '0;
			end
			r.received = received_acc;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] data);
			selection_t got;
			selection_t want;
			got.selected   = data[63:0];
			got.last_index = data[69:64];
			got.found      = data[70];
			got.received   = data[134:71];
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: selected %h last %0d found %0b received %h",
						got.selected, got.last_index, got.found, got.received);
				return;
			end
			want = expected_q.pop_front();
			if (got.selected !== want.selected || got.last_index !== want.last_index ||
				got.found !== want.found || got.received !== want.received) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch: selected exp %h got %h, last exp %0d got %0d",
						want.selected, got.selected, want.last_index, got.last_index);
					$display("  found exp %0b got %0b, received exp %h got %h",
						want.found, got.found, want.received, got.received);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;   // height[30:0], ready_mask[94:31], zero pad[95]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;   // selected_mask[63:0], last_index[69:64], found[70],
	                                   // received_mask[134:71], zero pad[135]
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_addr;
	logic [CFG_W-1:0]       cfg_wdata;

	selection_tracker tracker = new();

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	int hold_left;
	int cycles;

	rotating_first_m_selector u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// result side: check each transfer, then pick next tready
	initial begin
		m_tready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_request(input logic [HEIGHT_W-1:0] height, input logic [MASK_W-1:0] ready);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, ready, height};
		do @(posedge clk); while (!s_tready);
		tracker.note_request(height, ready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] pcount, input logic [CFG_W-1:0] rcount);
		settle();
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_PARTICIPANT_COUNT;
		cfg_wdata <= pcount;
		@(posedge clk);
		tracker.set_register(REG_PARTICIPANT_COUNT, pcount);
		cfg_addr  <= REG_REQUIRED_COUNT;
		cfg_wdata <= rcount;
		@(posedge clk);
		tracker.set_register(REG_REQUIRED_COUNT, rcount);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [MASK_W-1:0] random_ready();
		logic [MASK_W-1:0] a;
		logic [MASK_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(7))
			0, 1: return a;
			2: return a & b;
			3: return a | b;
			4: return 64'd1 << $urandom_range(63);
			5: return '1;
			6: return ~(64'd1 << $urandom_range(63));
			default: return a >> $urandom_range(63);
		endcase
	endfunction

	function automatic logic [HEIGHT_W-1:0] random_height();
		case ($urandom_range(3))
			0: return HEIGHT_W'($urandom_range(0, 150));
			1: return 31'h7FFF_FFFF - HEIGHT_W'($urandom_range(0, 150));
			default: return HEIGHT_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [CFG_W-1:0] pcount;
		logic [CFG_W-1:0] rcount;
		int n_eff;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_addr  <= REG_PARTICIPANT_COUNT;
		cfg_wdata <= '0;
		hold_request = 1'b0;
		send_idle_pct = 21;
		recv_idle_pct = 53;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: 64 participants, one pick
		send_request(31'd0, '1);
		send_request(31'h7FFF_FFFF, '0);
		send_request(31'd63, 64'd1);
		send_request(31'd69, 64'd1 << 63);
		// zero count and zero requirement
		configure(7'd0, 7'd0);
		send_request(31'h1234_5678, 64'd1);
		send_request(31'h7FFF_FFFF, ~64'd1);
		// count saturates, all 64 needed
		configure(7'd127, 7'd64);
		send_request(31'd17, '1);
		send_request(31'd17, ~(64'd1 << 3));
		// requirement out of reach
		configure(7'd64, 7'd65);
		send_request(31'd5, '1);
		configure(7'd100, 7'd127);
		send_request(31'd0, '1);
		// ready bits past the count
		configure(7'd5, 7'd3);
		send_request(31'd7, 64'hFFFF_FFFF_FFFF_FFE0);
		send_request(31'd7, 64'h1F);
		send_request(31'd4, 64'h13);
		configure(7'd33, 7'd2);
		send_request(31'd32, (64'd1 << 32) | 64'd3);
		configure(7'd2, 7'd1);
		send_request(31'h7FFF_FFFF, 64'h3);
		send_request(31'h7FFF_FFFE, 64'h2);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 21; recv_idle_pct = 53; end
				1: begin send_idle_pct = 53; recv_idle_pct = 21; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int seg = 0; seg < 6; seg++) begin
				case ($urandom_range(9))
					0: pcount = 7'd0;
					1: pcount = CFG_W'($urandom_range(65, 127));
					2: pcount = 7'd64;
					default: pcount = CFG_W'($urandom_range(1, 64));
				endcase
				n_eff = (pcount == 0) ? 1 : (pcount > 64) ? 64 : int'(pcount);
				case ($urandom_range(9))
					0: rcount = 7'd0;
					1: rcount = CFG_W'($urandom_range(65, 127));
					2, 3: rcount = CFG_W'($urandom_range(1, 3));
					default: rcount = CFG_W'($urandom_range(1, n_eff));
				endcase
				configure(pcount, rcount);
				if (phase == 2 && seg == 2)
					hold_request = 1'b1;
				for (int i = 0; i < 100; i++)
					send_request(random_height(), random_ready());
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
